>>> src/aet_pkg.sv
// ----------------------------------------------------------------------------
// aet_pkg: shared types and constants for the expression tokenizer
// Token kinds, scanner modes, character codes, field widths and the
// saturated mantissa value.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package aet_pkg;

    // Sizing
    localparam int MAX_DIGITS    = 18;
    localparam int POSITION_BITS = 16;
    localparam int MAX_RESULTS   = 4;
    localparam int CNT_W         = $clog2(MAX_RESULTS + 1);
    localparam int DIGCNT_W      = $clog2(MAX_DIGITS + 1);

    // Field widths
    localparam int CHAR_W   = 8;
    localparam int KIND_W   = 4;
    localparam int MANT_W   = 60;
    localparam int PLACES_W = 6;
    localparam int ERRPOS_W = 16;
    localparam int ACC_W    = MANT_W + 4;

    localparam logic [MANT_W-1:0]        MANT_LIMIT   = {MANT_W{1'b1}};
    localparam logic [PLACES_W-1:0]      PLACES_LIMIT = {PLACES_W{1'b1}};
    localparam logic [POSITION_BITS-1:0] POS_LIMIT    = {POSITION_BITS{1'b1}};
    localparam logic [ERRPOS_W-1:0]      ERRPOS_LIMIT = {ERRPOS_W{1'b1}};

    // Largest MAX_DIGITS-digit value, clipped to the mantissa field
    function automatic logic [MANT_W-1:0] mant_saturated();
        logic [ACC_W-1:0] v;
        v = '0;
        for (int i = 0; i < MAX_DIGITS; i++) begin
            if (v <= ACC_W'(MANT_LIMIT))
                v = v * ACC_W'(10) + ACC_W'(9);
        end
        if (v > ACC_W'(MANT_LIMIT))
            v = ACC_W'(MANT_LIMIT);
        return v[MANT_W-1:0];
    endfunction

    localparam logic [MANT_W-1:0] MANT_SAT = mant_saturated();

    // Character codes
    localparam logic [CHAR_W-1:0] CH_DOT    = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
    localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
    localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;

    typedef enum logic [KIND_W-1:0] {
        TK_LPAREN     = 4'd0,
        TK_RPAREN     = 4'd1,
        TK_PLUS       = 4'd2,
        TK_MINUS      = 4'd3,
        TK_SLASH      = 4'd4,
        TK_STAR       = 4'd5,
        TK_NUMBER     = 4'd6,
        TK_UNEXPECTED = 4'd7,
        TK_END        = 4'd8
    } token_kind_t;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_INT  = 2'd1,
        MODE_DOT  = 2'd2,
        MODE_FRAC = 2'd3
    } scan_mode_t;

    typedef struct packed {
        token_kind_t           kind;
        logic [MANT_W-1:0]     mantissa;
        logic [PLACES_W-1:0]   places;
        logic                  overflow;
        logic [ERRPOS_W-1:0]   err_pos;
        logic [CHAR_W-1:0]     err_char;
        logic                  any_error;
        logic                  last;
    } token_t;

endpackage

>>> src/arith_expr_tokenizer.sv
// ----------------------------------------------------------------------------
// arith_expr_tokenizer: character-stream lexer for arithmetic expressions
// Turns characters into paren, operator, number, unexpected and end tokens.
// ----------------------------------------------------------------------------
// Usage:
//  - s_ channel: one character per transaction, s_end_of_text on the last
//    character of a non-empty string.
//  - m_ channel: one token per transaction; m_last_result marks the final
//    token caused by a character. A character yields 0 to 4 tokens.
//  - Latency: tokens of a character are registered; the first shows on m_
//    the cycle after the character is taken.
//  - Throughput: one character per cycle while each yields at most one
//    token and m_ready is high. A character yielding several tokens holds
//    the output queue until they leave; the next character is taken in the
//    cycle its last token leaves (or at once if it yields none). The mantissa
//    update is one times-ten add and compare, done in the accept cycle.
//  - Reset (aresetn low, synchronous): scanner idle, position zero, output
//    queue empty. No clearing pass.
//  - When m_ready is low, finished tokens wait in the four-entry queue and
//    s_ready stays low while any token is pending.
//  - After the last character of a string all scan state returns to reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module arith_expr_tokenizer (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [aet_pkg::CHAR_W-1:0]           s_char_code,
    input  logic                                 s_end_of_text,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [aet_pkg::KIND_W-1:0]           m_token_kind,
    output logic [aet_pkg::MANT_W-1:0]           m_mantissa,
    output logic [aet_pkg::PLACES_W-1:0]         m_decimal_places,
    output logic                                 m_number_overflow,
    output logic [aet_pkg::ERRPOS_W-1:0]         m_error_position,
    output logic [aet_pkg::CHAR_W-1:0]           m_error_char,
    output logic                                 m_any_error,
    output logic                                 m_last_result
);
    import aet_pkg::*;

    // Scanner state
    scan_mode_t                 mode_reg, mode_next;
    logic [MANT_W-1:0]          acc_reg, acc_next;
    logic [PLACES_W-1:0]        places_reg, places_next;
    logic [DIGCNT_W-1:0]        dcnt_reg, dcnt_next;
    logic                       ovf_reg, ovf_next;
    logic [POSITION_BITS-1:0]   pos_reg, pos_next;
    logic                       err_reg, err_next;

    // Output queue, head at entry 0
    token_t                     q_reg [MAX_RESULTS];
    token_t                     q_next [MAX_RESULTS];
    logic [CNT_W-1:0]           qcnt_reg, qcnt_next;

    // Tokens built for the current character
    token_t                     list [MAX_RESULTS];
    logic [CNT_W-1:0]           n;

    logic                       accept;
    logic                       pop;
    logic                       is_digit;
    logic [3:0]                 digit;
    logic                       handle_char;

    // Digit accumulate unit
    logic [ACC_W-1:0]           acc_x10;
    logic [MANT_W-1:0]          add_acc;
    logic [DIGCNT_W-1:0]        add_dcnt;
    logic                       add_ovf;
    logic [PLACES_W-1:0]        add_places;
    logic                       add_frac;

    logic [ERRPOS_W-1:0]        pos_err;
    logic [ERRPOS_W-1:0]        pos_err_m1;

    // Handshake
    assign pop     = m_valid && m_ready;
    assign m_valid = (qcnt_reg != '0);
    assign s_ready = (qcnt_reg == '0) || ((qcnt_reg == CNT_W'(1)) && m_ready);
    assign accept  = s_valid && s_ready;

    assign is_digit = (s_char_code inside {[CH_ZERO:CH_NINE]});
    assign digit    = 4'(s_char_code - CH_ZERO);

    // Position clipped to the error field
    function automatic logic [ERRPOS_W-1:0] clip_pos(input logic [POSITION_BITS-1:0] p);
        logic [32:0] wide;
        wide = 33'(p);
        if (wide > 33'(ERRPOS_LIMIT))
            return ERRPOS_LIMIT;
        return ERRPOS_W'(p);
    endfunction

    assign pos_err    = clip_pos(pos_reg);
    assign pos_err_m1 = clip_pos((pos_reg == '0) ? '0 : pos_reg - POSITION_BITS'(1));

    // Token builders
    function automatic token_t tok_simple(input token_kind_t k);
        token_t t;
        t      = '0;
        t.kind = k;
        return t;
    endfunction

    function automatic token_t tok_number(input logic [MANT_W-1:0] m,
                                          input logic [PLACES_W-1:0] p,
                                          input logic o);
        token_t t;
        t          = '0;
        t.kind     = TK_NUMBER;
        t.mantissa = m;
        t.places   = p;
        t.overflow = o;
        return t;
    endfunction

    function automatic token_t tok_unexp(input logic [ERRPOS_W-1:0] p,
                                         input logic [CHAR_W-1:0] c);
        token_t t;
        t          = '0;
        t.kind     = TK_UNEXPECTED;
        t.err_pos  = p;
        t.err_char = c;
        return t;
    endfunction

    function automatic token_t tok_end(input logic e);
        token_t t;
        t           = '0;
        t.kind      = TK_END;
        t.any_error = e;
        return t;
    endfunction

    // One digit into the accumulator: acc*10 + d, saturating
    assign add_frac = (mode_reg == MODE_DOT) || (mode_reg == MODE_FRAC);
    assign acc_x10  = (ACC_W'(acc_reg) << 3) + (ACC_W'(acc_reg) << 1) + ACC_W'(digit);

    always_comb begin
        add_acc  = acc_reg;
        add_dcnt = dcnt_reg;
        add_ovf  = ovf_reg;
        if (ovf_reg || (dcnt_reg >= DIGCNT_W'(MAX_DIGITS))) begin
            add_ovf = 1'b1;
            add_acc = MANT_SAT;
        end else begin
            if (acc_x10 > ACC_W'(MANT_LIMIT)) begin
                add_ovf = 1'b1;
                add_acc = MANT_SAT;
            end else begin
                add_acc = acc_x10[MANT_W-1:0];
            end
            add_dcnt = dcnt_reg + DIGCNT_W'(1);
        end
        add_places = places_reg;
        if (add_frac && (places_reg < PLACES_LIMIT))
            add_places = places_reg + PLACES_W'(1);
    end

    // Next scan state and token list for the offered character
    always_comb begin
        mode_next   = mode_reg;
        acc_next    = acc_reg;
        places_next = places_reg;
        dcnt_next   = dcnt_reg;
        ovf_next    = ovf_reg;
        err_next    = err_reg;
        pos_next    = (pos_reg < POS_LIMIT) ? pos_reg + POSITION_BITS'(1) : pos_reg;
        handle_char = 1'b0;
        n           = '0;
        for (int i = 0; i < MAX_RESULTS; i++)
            list[i] = '0;

        case (mode_reg)
            MODE_DOT: begin
                if (is_digit) begin
                    mode_next   = MODE_FRAC;
                    acc_next    = add_acc;
                    dcnt_next   = add_dcnt;
                    ovf_next    = add_ovf;
                    places_next = add_places;
                end else begin
                    // held dot not followed by a digit
                    list[n[1:0]] = tok_number(acc_reg, places_reg, ovf_reg);
                    n            = n + CNT_W'(1);
                    list[n[1:0]] = tok_unexp(pos_err_m1, CH_DOT);
                    n            = n + CNT_W'(1);
                    err_next     = 1'b1;
                    mode_next    = MODE_IDLE;
                    acc_next     = '0;
                    places_next  = '0;
                    dcnt_next    = '0;
                    ovf_next     = 1'b0;
                    handle_char  = 1'b1;
                end
            end
            MODE_INT, MODE_FRAC: begin
                if (is_digit) begin
                    acc_next    = add_acc;
                    dcnt_next   = add_dcnt;
                    ovf_next    = add_ovf;
                    places_next = add_places;
                end else if ((s_char_code == CH_DOT) && (mode_reg == MODE_INT)) begin
                    mode_next = MODE_DOT;
                end else begin
                    list[n[1:0]] = tok_number(acc_reg, places_reg, ovf_reg);
                    n            = n + CNT_W'(1);
                    mode_next    = MODE_IDLE;
                    acc_next     = '0;
                    places_next  = '0;
                    dcnt_next    = '0;
                    ovf_next     = 1'b0;
                    handle_char  = 1'b1;
                end
            end
            default: begin
                handle_char = 1'b1;
            end
        endcase

        // Character outside a number
        if (handle_char) begin
            case (s_char_code)
                CH_LPAREN: begin
                    list[n[1:0]] = tok_simple(TK_LPAREN);
                    n            = n + CNT_W'(1);
                end
                CH_RPAREN: begin
                    list[n[1:0]] = tok_simple(TK_RPAREN);
                    n            = n + CNT_W'(1);
                end
                CH_PLUS: begin
                    list[n[1:0]] = tok_simple(TK_PLUS);
                    n            = n + CNT_W'(1);
                end
                CH_MINUS: begin
                    list[n[1:0]] = tok_simple(TK_MINUS);
                    n            = n + CNT_W'(1);
                end
                CH_SLASH: begin
                    list[n[1:0]] = tok_simple(TK_SLASH);
                    n            = n + CNT_W'(1);
                end
                CH_STAR: begin
                    list[n[1:0]] = tok_simple(TK_STAR);
                    n            = n + CNT_W'(1);
                end
                CH_SPACE, CH_TAB, CH_CR, CH_LF: begin
                end
                default: begin
                    if (is_digit) begin
                        // only reached from idle, where number state is clear
                        mode_next   = MODE_INT;
                        acc_next    = add_acc;
                        dcnt_next   = add_dcnt;
                        ovf_next    = add_ovf;
                        places_next = places_reg;
                    end else begin
                        list[n[1:0]] = tok_unexp(pos_err, s_char_code);
                        n            = n + CNT_W'(1);
                        err_next     = 1'b1;
                    end
                end
            endcase
        end

        // End of string: close any number, add the end token, back to reset
        if (s_end_of_text) begin
            if ((mode_next == MODE_INT) || (mode_next == MODE_FRAC)) begin
                list[n[1:0]] = tok_number(acc_next, places_next, ovf_next);
                n            = n + CNT_W'(1);
            end else if (mode_next == MODE_DOT) begin
                list[n[1:0]] = tok_number(acc_next, places_next, ovf_next);
                n            = n + CNT_W'(1);
                list[n[1:0]] = tok_unexp(pos_err, CH_DOT);
                n            = n + CNT_W'(1);
                err_next     = 1'b1;
            end
            list[n[1:0]] = tok_end(err_next);
            n            = n + CNT_W'(1);
            mode_next    = MODE_IDLE;
            acc_next     = '0;
            places_next  = '0;
            dcnt_next    = '0;
            ovf_next     = 1'b0;
            pos_next     = '0;
            err_next     = 1'b0;
        end

        if (n != '0)
            list[n[1:0] - 2'd1].last = 1'b1;
    end

    // Scan state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_IDLE;
            acc_reg    <= '0;
            places_reg <= '0;
            dcnt_reg   <= '0;
            ovf_reg    <= 1'b0;
            pos_reg    <= '0;
            err_reg    <= 1'b0;
        end else if (accept) begin
            mode_reg   <= mode_next;
            acc_reg    <= acc_next;
            places_reg <= places_next;
            dcnt_reg   <= dcnt_next;
            ovf_reg    <= ovf_next;
            pos_reg    <= pos_next;
            err_reg    <= err_next;
        end
    end

    // Output queue: load on accept, shift on pop
    always_comb begin
        for (int i = 0; i < MAX_RESULTS; i++)
            q_next[i] = q_reg[i];
        qcnt_next = qcnt_reg;
        if (accept) begin
            for (int i = 0; i < MAX_RESULTS; i++)
                q_next[i] = list[i];
            qcnt_next = n;
        end else if (pop) begin
            for (int i = 0; i < MAX_RESULTS - 1; i++)
                q_next[i] = q_reg[i + 1];
            qcnt_next = qcnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            qcnt_reg <= '0;
        end else begin
            qcnt_reg <= qcnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < MAX_RESULTS; i++)
            q_reg[i] <= q_next[i];
    end

    // Output ports from the queue head
    assign m_token_kind      = KIND_W'(q_reg[0].kind);
    assign m_mantissa        = q_reg[0].mantissa;
    assign m_decimal_places  = q_reg[0].places;
    assign m_number_overflow = q_reg[0].overflow;
    assign m_error_position  = q_reg[0].err_pos;
    assign m_error_char      = q_reg[0].err_char;
    assign m_any_error       = q_reg[0].any_error;
    assign m_last_result     = q_reg[0].last;

    // Checks
    a_qcnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        qcnt_reg <= CNT_W'(MAX_RESULTS))
        else $error("output queue count out of range");

    a_idle_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg == MODE_IDLE) |-> ((acc_reg == '0) && (dcnt_reg == '0) &&
                                     (places_reg == '0) && !ovf_reg))
        else $error("number state not clear outside a number");

    a_ovf_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        ovf_reg |-> (acc_reg == MANT_SAT))
        else $error("overflowed mantissa not saturated");

    a_eot_reset: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_end_of_text) |=>
            ((mode_reg == MODE_IDLE) && (pos_reg == '0) && !err_reg))
        else $error("scan state not reset after end of text");

    a_end_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_token_kind == KIND_W'(TK_END))) |->
            (m_last_result && (qcnt_reg == CNT_W'(1))))
        else $error("end token is not the final queued token");

endmodule

>>> tb/tb_arith_expr_tokenizer.sv
// ----------------------------------------------------------------------------
// tb_arith_expr_tokenizer: self-checking bench for the expression tokenizer
// Streams characters into the block and predicts every token it should
// emit. The stimulus has three parts. A short directed part covers each
// operator, whitespace and the awkward cases around a dangling point.
// Random expression strings follow, mostly well formed and partly noise.
// One long fraction then saturates the decimal places. Accepted tokens
// are checked field by field against the predicted queue, in order.
// Both channels stall at random, except in the last random phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_arith_expr_tokenizer;

    import aet_pkg::*;

    localparam int          TIMEOUT_NS  = 5_000_000;
    localparam int          PHASE_CHARS = 100;
    localparam int          DIGIT_LIMIT = 18;
    // Eighteen nines; fits below 2^60 - 1
    localparam logic [MANT_W-1:0] ALL_NINES = 60'd999_999_999_999_999_999;
    localparam logic [63:0]       MANT_MAX  = (64'd1 << MANT_W) - 64'd1;

    // Token predictor and in-order checker
    class token_scoreboard;
        token_t                expected_tokens[$];
        int                    failures;
        scan_mode_t            mode;
        logic [MANT_W-1:0]     accum;
        logic [PLACES_W-1:0]   places;
        int                    digits;
        logic                  overflow;
        logic [ERRPOS_W-1:0]   position;
        logic                  error_flag;

        function new();
            failures = 0;
            clear_scan();
        endfunction

        function void clear_scan();
            mode       = MODE_IDLE;
            accum      = '0;
            places     = '0;
            digits     = 0;
            overflow   = 1'b0;
            position   = '0;
            error_flag = 1'b0;
        endfunction

        function int pending();
            return expected_tokens.size();
        endfunction

        function void push_token(token_kind_t kind, logic [MANT_W-1:0] mant,
                                 logic [PLACES_W-1:0] plc, logic ovf,
                                 logic [ERRPOS_W-1:0] epos, logic [CHAR_W-1:0] ech,
                                 logic anyerr);
            token_t t;
            t.kind      = kind;
            t.mantissa  = mant;
            t.places    = plc;
            t.overflow  = ovf;
            t.err_pos   = epos;
            t.err_char  = ech;
            t.any_error = anyerr;
            t.last      = 1'b0;
            expected_tokens.push_back(t);
        endfunction

        function void close_number();
            push_token(TK_NUMBER, accum, places, overflow, '0, '0, 1'b0);
            accum    = '0;
            places   = '0;
            digits   = 0;
            overflow = 1'b0;
            mode     = MODE_IDLE;
        endfunction

        function void flag_char(logic [ERRPOS_W-1:0] epos, logic [CHAR_W-1:0] ech);
            push_token(TK_UNEXPECTED, '0, '0, 1'b0, epos, ech, 1'b0);
            error_flag = 1'b1;
        endfunction

        // Multiply-by-ten accumulate, saturating past the digit limit
        function void take_digit(logic [3:0] d, bit frac);
            logic [63:0] v;
            if (overflow || digits >= DIGIT_LIMIT) begin
                overflow = 1'b1;
                accum    = ALL_NINES;
            end else begin
                v = 64'(accum) * 64'd10 + 64'(d);
                if (v > MANT_MAX) begin
                    overflow = 1'b1;
                    accum    = ALL_NINES;
                end else begin
                    accum = v[MANT_W-1:0];
                end
                digits++;
            end
            if (frac && places != '1)
                places++;
        endfunction

        // Predict the tokens caused by one accepted character
        function void note_char(logic [CHAR_W-1:0] code, logic eot);
            logic [ERRPOS_W-1:0] here;
            bit                  is_digit;
            bit                  handled;
            int                  first;
            token_t              tail;
            here     = position;
            handled  = 0;
            first    = expected_tokens.size();
            is_digit = (code >= CH_ZERO) && (code <= CH_NINE);

            // point held from the previous character
            if (mode == MODE_DOT) begin
                if (is_digit) begin
                    mode = MODE_FRAC;
                    take_digit(code[3:0], 1'b1);
                    handled = 1;
                end else begin
                    close_number();
                    flag_char((here != '0) ? here - 1'b1 : '0, CH_DOT);
                end
            end

            // inside a number
            if (!handled && (mode == MODE_INT || mode == MODE_FRAC)) begin
                if (is_digit) begin
                    take_digit(code[3:0], mode == MODE_FRAC);
                    handled = 1;
                end else if (code == CH_DOT && mode == MODE_INT) begin
                    mode    = MODE_DOT;
                    handled = 1;
                end else begin
                    close_number();
                end
            end

            if (!handled) begin
                case (code)
                    CH_LPAREN: push_token(TK_LPAREN, '0, '0, 1'b0, '0, '0, 1'b0);
                    CH_RPAREN: push_token(TK_RPAREN, '0, '0, 1'b0, '0, '0, 1'b0);
                    CH_PLUS:   push_token(TK_PLUS,   '0, '0, 1'b0, '0, '0, 1'b0);
                    CH_MINUS:  push_token(TK_MINUS,  '0, '0, 1'b0, '0, '0, 1'b0);
                    CH_SLASH:  push_token(TK_SLASH,  '0, '0, 1'b0, '0, '0, 1'b0);
                    CH_STAR:   push_token(TK_STAR,   '0, '0, 1'b0, '0, '0, 1'b0);
                    CH_SPACE, CH_TAB, CH_CR, CH_LF: ;
                    default: begin
                        if (is_digit) begin
                            mode = MODE_INT;
                            take_digit(code[3:0], 1'b0);
                        end else begin
                            flag_char(here, code);
                        end
                    end
                endcase
            end

            if (position != '1)
                position++;

            // last character: close any open number, then the end token
            if (eot) begin
                if (mode == MODE_INT || mode == MODE_FRAC) begin
                    close_number();
                end else if (mode == MODE_DOT) begin
                    close_number();
                    flag_char(here, CH_DOT);
                end
                push_token(TK_END, '0, '0, 1'b0, '0, '0, error_flag);
                clear_scan();
            end

            if (expected_tokens.size() > first) begin
                tail      = expected_tokens[expected_tokens.size()-1];
                tail.last = 1'b1;
                expected_tokens[expected_tokens.size()-1] = tail;
            end
        endfunction

        function string show(token_t t);
            return $sformatf({"kind=%0d mant=%0d places=%0d ovf=%0b pos=%0d ",
                              "ch=%02h err=%0b last=%0b"},
                             t.kind, t.mantissa, t.places, t.overflow, t.err_pos,
                             t.err_char, t.any_error, t.last);
        endfunction

        function void check_token(token_t got);
            token_t want;
            if (expected_tokens.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("unexpected token, none pending: %s", show(got));
            end else begin
                want = expected_tokens.pop_front();
                if (got !== want) begin
                    failures++;
                    if (failures <= 10) begin
                        $display("token mismatch at %0t", $realtime);
                        $display("  expected %s", show(want));
                        $display("  actual   %s", show(got));
                    end
                end
            end
        endfunction
    endclass

    logic                   aclk;
    logic                   aresetn        = 1'b0;
    logic                   s_valid        = 1'b0;
    logic                   s_ready;
    logic [CHAR_W-1:0]      s_char_code    = '0;
    logic                   s_end_of_text  = 1'b0;
    logic                   m_valid;
    logic                   m_ready        = 1'b0;
    logic [KIND_W-1:0]      m_token_kind;
    logic [MANT_W-1:0]      m_mantissa;
    logic [PLACES_W-1:0]    m_decimal_places;
    logic                   m_number_overflow;
    logic [ERRPOS_W-1:0]    m_error_position;
    logic [CHAR_W-1:0]      m_error_char;
    logic                   m_any_error;
    logic                   m_last_result;

    token_scoreboard        sb = new();
    int                     src_idle_pct  = 33;
    int                     sink_idle_pct = 54;
    int                     chars_sent    = 0;
    logic [CHAR_W-1:0]      text_buf[$];

    arith_expr_tokenizer uut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_char_code       (s_char_code),
        .s_end_of_text     (s_end_of_text),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_token_kind      (m_token_kind),
        .m_mantissa        (m_mantissa),
        .m_decimal_places  (m_decimal_places),
        .m_number_overflow (m_number_overflow),
        .m_error_position  (m_error_position),
        .m_error_char      (m_error_char),
        .m_any_error       (m_any_error),
        .m_last_result     (m_last_result)
    );

    // Clock
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Run limit
    initial begin
        #(TIMEOUT_NS);
        $display("tb_arith_expr_tokenizer: FAIL");
        $finish;
    end

    // Token sink: check each transaction, stall at random
    initial begin
        token_t got;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                got.kind      = token_kind_t'(m_token_kind);
                got.mantissa  = m_mantissa;
                got.places    = m_decimal_places;
                got.overflow  = m_number_overflow;
                got.err_pos   = m_error_position;
                got.err_char  = m_error_char;
                got.any_error = m_any_error;
                got.last      = m_last_result;
                sb.check_token(got);
            end
            m_ready <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    // One character transaction; valid stays up for a back-to-back follower
    task automatic send_char(input logic [CHAR_W-1:0] code, input logic last_char);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_char_code   <= code;
        s_end_of_text <= last_char;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        sb.note_char(code, last_char);
        chars_sent++;
    endtask

    task automatic send_str(input string s, input bit closes);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], closes && (i == s.len() - 1));
    endtask

    task automatic send_buffer();
        for (int i = 0; i < text_buf.size(); i++)
            send_char(text_buf[i], i == text_buf.size() - 1);
    endtask

    // Hold the input until every pending token has drained
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
    endtask

    task automatic add_digits(input int count, input bit nines);
        repeat (count)
            text_buf.push_back(nines ? CH_NINE : CH_ZERO + 8'($urandom_range(0, 9)));
    endtask

    // Integer part, optional fraction or a dangling point
    task automatic add_number();
        int int_len;
        bit nines;
        int_len = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 24)
                                              : $urandom_range(1, 4);
        nines   = ($urandom_range(0, 5) == 0);
        add_digits(int_len, nines);
        case ($urandom_range(0, 5))
            0, 1: begin
                text_buf.push_back(CH_DOT);
                add_digits($urandom_range(1, 4), nines);
            end
            2: text_buf.push_back(CH_DOT);
            default: ;
        endcase
    endtask

    // Random expression string: mostly valid pieces, some noise
    task automatic build_expression();
        int pick;
        text_buf.delete();
        repeat ($urandom_range(1, 8)) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                add_number();
            end else if (pick < 65) begin
                case ($urandom_range(0, 3))
                    0: text_buf.push_back(CH_PLUS);
                    1: text_buf.push_back(CH_MINUS);
                    2: text_buf.push_back(CH_SLASH);
                    default: text_buf.push_back(CH_STAR);
                endcase
            end else if (pick < 75) begin
                text_buf.push_back($urandom_range(0, 1) ? CH_LPAREN : CH_RPAREN);
            end else if (pick < 85) begin
                case ($urandom_range(0, 3))
                    0: text_buf.push_back(CH_SPACE);
                    1: text_buf.push_back(CH_TAB);
                    2: text_buf.push_back(CH_CR);
                    default: text_buf.push_back(CH_LF);
                endcase
            end else if (pick < 93) begin
                text_buf.push_back(8'($urandom_range(0, 255)));
            end else begin
                text_buf.push_back(CH_DOT);
            end
        end
    endtask

    // Stimulus
    initial begin
        int phase_start;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // operators, parens, whitespace, point followed by a non-digit
        send_str("(1.5+2.)/*", 0);
        send_char(CH_TAB, 0);
        send_char(CH_CR, 0);
        send_char(CH_LF, 1);
        // point after fraction digits
        send_str("1.2.-", 1);
        // NUL and high codes
        send_char(8'h00, 0);
        send_char(8'hFF, 0);
        send_char(8'h80, 1);
        // held point then an unexpected last character: four tokens
        send_str("5.#", 1);
        // string ends on a held point
        send_str("3.", 1);
        wait_drained();

        for (int phase = 0; phase < 3; phase++) begin
            src_idle_pct  = (phase == 0) ? 33 : (phase == 1) ? 54 : 0;
            sink_idle_pct = (phase == 0) ? 54 : (phase == 1) ? 33 : 0;
            phase_start   = chars_sent;
            while (chars_sent - phase_start < PHASE_CHARS) begin
                build_expression();
                send_buffer();
            end
            wait_drained();
        end

        // long fraction: places past 63, then a few mixed endings
        text_buf.delete();
        text_buf.push_back(CH_ZERO);
        text_buf.push_back(CH_DOT);
        repeat (70) text_buf.push_back(CH_ZERO + 8'd7);
        text_buf.push_back(8'h23);
        text_buf.push_back(CH_ZERO + 8'd1);
        text_buf.push_back(CH_ZERO + 8'd2);
        text_buf.push_back(CH_DOT);
        text_buf.push_back(8'h78);
        text_buf.push_back(CH_ZERO + 8'd3);
        text_buf.push_back(CH_DOT);
        send_buffer();
        wait_drained();

        // settle, then make sure nothing extra shows up
        repeat (16) @(posedge aclk);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("tb_arith_expr_tokenizer: PASS");
        else
            $display("tb_arith_expr_tokenizer: FAIL");
        $finish;
    end

endmodule

>>> sim.f
src/aet_pkg.sv
src/arith_expr_tokenizer.sv
tb/tb_arith_expr_tokenizer.sv
